[sv/scrb_pkg.sv]
package scrb_pkg;

  // Default number of bytes in the register bank.
  localparam int unsigned BANK_SIZE_DEFAULT = 10;

  // Command bytes after reset.
  localparam logic [7:0] WRITE_CMD_RESET = 8'h2a;
  localparam logic [7:0] READ_CMD_RESET  = 8'h23;

  // Configuration register indexes.
  localparam logic CFG_WRITE_CMD = 1'b0;
  localparam logic CFG_READ_CMD  = 1'b1;

  // One received byte held in the input stage.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } scrb_stage_t;

  // One result beat.
  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       write_done;
    logic       index_error;
    logic       frame_end;
  } scrb_result_t;

endpackage

[sv/scrb_in_reg.sv]
module scrb_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               advance_i,
  output logic               in_stall_o,
  output scrb_pkg::scrb_stage_t stage_o
);
  import scrb_pkg::*;

  logic       valid_q;
  logic [7:0] data_q;
  logic       load;

  // The stage can take a new beat when empty or when its beat moves on.
  assign load       = !valid_q || advance_i;
  assign in_stall_o = !load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      data_q <= rx_byte_i;
    end
  end

  assign stage_o = '{valid: valid_q, data: data_q};

endmodule

[sv/scrb_core.sv]
module scrb_core #(
  parameter int unsigned BANK_SIZE = scrb_pkg::BANK_SIZE_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [7:0]             cfg_data_i,
  input  logic                   step_i,
  input  logic [7:0]             data_i,
  output scrb_pkg::scrb_result_t result_o
);
  import scrb_pkg::*;

  localparam int unsigned IdxW = (BANK_SIZE > 1) ? $clog2(BANK_SIZE) : 1;
  localparam logic [7:0]  BankLimit = 8'(BANK_SIZE);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_W_INDEX,
    PH_W_DATA,
    PH_R_INDEX,
    PH_R_DUMMY
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] held_index_q, held_index_d;
  logic [7:0] write_cmd_q;
  logic [7:0] read_cmd_q;
  logic [7:0] bank_q [BANK_SIZE];
  logic       bank_we;
  logic       held_in_range;
  logic       data_in_range;
  logic [7:0] bank_rd;

  assign held_in_range = held_index_q < BankLimit;
  assign data_in_range = data_i < BankLimit;
  assign bank_rd       = data_in_range ? bank_q[data_i[IdxW-1:0]] : 8'h00;

  always_comb begin
    phase_d      = phase_q;
    held_index_d = held_index_q;
    bank_we      = 1'b0;
    result_o     = '0;
    case (phase_q)
      PH_W_INDEX: begin
        held_index_d = data_i;
        phase_d      = PH_W_DATA;
      end
      PH_W_DATA: begin
        bank_we              = held_in_range;
        phase_d              = PH_IDLE;
        result_o.write_done  = held_in_range;
        result_o.index_error = !held_in_range;
        result_o.frame_end   = 1'b1;
      end
      PH_R_INDEX: begin
        held_index_d         = data_i;
        phase_d              = PH_R_DUMMY;
        result_o.reply_valid = 1'b1;
        result_o.reply_byte  = bank_rd;
        result_o.index_error = !data_in_range;
      end
      PH_R_DUMMY: begin
        phase_d            = PH_IDLE;
        result_o.frame_end = 1'b1;
      end
      default: begin
        // A write match wins when both commands hold the same value.
        if (data_i == write_cmd_q) begin
          phase_d = PH_W_INDEX;
        end else if (data_i == read_cmd_q) begin
          phase_d = PH_R_INDEX;
        end else begin
          phase_d            = PH_IDLE;
          result_o.frame_end = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      held_index_q <= 8'h00;
      write_cmd_q  <= WRITE_CMD_RESET;
      read_cmd_q   <= READ_CMD_RESET;
      for (int i = 0; i < BANK_SIZE; i++) begin
        bank_q[i] <= 8'h00;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_WRITE_CMD: write_cmd_q <= cfg_data_i;
          CFG_READ_CMD:  read_cmd_q  <= cfg_data_i;
          default:       ;
        endcase
      end
      if (step_i) begin
        phase_q      <= phase_d;
        held_index_q <= held_index_d;
        if (bank_we) begin
          bank_q[held_index_q[IdxW-1:0]] <= data_i;
        end
      end
    end
  end

endmodule

[sv/scrb_out_reg.sv]
module scrb_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  scrb_pkg::scrb_result_t result_i,
  input  logic                   out_stall_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  output scrb_pkg::scrb_result_t result_o
);
  import scrb_pkg::*;

  logic         valid_q;
  scrb_result_t result_q;

  // Free when empty or when the held beat leaves this cycle.
  assign ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

[sv/serial_command_register_bank.sv]
// Serial command register bank.
//
// Each beat on the input channel (in_valid_i, in_stall_o, rx_byte_i) is one
// byte received from the serial master. Bytes form three-byte frames: the
// write command, an index and a data byte store the data in the bank; the
// read command, an index and a dummy byte return the stored byte as the reply
// on the index byte. Any other first byte is a lone byte and ends at once.
// Every input beat yields exactly one output beat (out_valid_o, out_stall_i
// and the reply and status fields), in order.
//
// A byte passes through the input register and then the result register.
// Throughput is one byte per cycle while the receiver does not stall, set by
// the phase update and bank access between those two registers.
// Reset clears the pipeline, returns the frame parser to idle, zeroes the
// bank and restores the write command 0x2a and read command 0x23. The user
// must write the command bytes through cfg_we_i, cfg_index_i and cfg_data_i
// only while idle; the block itself does not enforce this. When the receiver
// stalls, the result register holds its beat and the input register fills;
// after that in_stall_o rises until the receiver drains.
module serial_command_register_bank #(
  parameter int unsigned BANK_SIZE = scrb_pkg::BANK_SIZE_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       reply_valid_o,
  output logic [7:0] reply_byte_o,
  output logic       write_done_o,
  output logic       index_error_o,
  output logic       frame_end_o
);
  import scrb_pkg::*;

  scrb_stage_t  stage;
  scrb_result_t core_result;
  scrb_result_t out_result;
  logic         out_ready;
  logic         advance;

  // A byte is parsed in the cycle it moves from the input register into
  // the result register; the parser state steps only then.
  assign advance = stage.valid && out_ready;

  scrb_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .in_stall_o (in_stall_o),
    .stage_o    (stage)
  );

  scrb_core #(
    .BANK_SIZE (BANK_SIZE)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (advance),
    .data_i      (stage.data),
    .result_o    (core_result)
  );

  scrb_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (stage.valid),
    .result_i    (core_result),
    .out_stall_i (out_stall_i),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .result_o    (out_result)
  );

  assign reply_valid_o = out_result.reply_valid;
  assign reply_byte_o  = out_result.reply_byte;
  assign write_done_o  = out_result.write_done;
  assign index_error_o = out_result.index_error;
  assign frame_end_o   = out_result.frame_end;

endmodule

[dv/scrb_frame_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the register bank, predicts every result beat from
// the accepted input beats and the command bytes written so far, and compares
// each accepted result beat with the oldest prediction.
module scrb_frame_checker #(
  parameter int unsigned BANK_SIZE = scrb_pkg::BANK_SIZE_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] rx_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       reply_valid_i,
  input  logic [7:0] reply_byte_i,
  input  logic       write_done_i,
  input  logic       index_error_i,
  input  logic       frame_end_i,
  output int         owed_count_o,
  output int         fail_count_o
);
  import scrb_pkg::*;

  typedef enum logic [2:0] {
    AWAIT_CMD,
    WR_INDEX,
    WR_DATA,
    RD_INDEX,
    RD_DUMMY
  } frame_phase_e;

  frame_phase_e   parse_phase;
  logic [7:0]     write_cmd;
  logic [7:0]     read_cmd;
  logic [7:0]     held_index;
  // Covers every byte value so that any index byte addresses an entry; only
  // entries below BANK_SIZE are ever written or read.
  logic [7:0]     bank_copy [256];
  scrb_result_t   owed_results [$];

  // Advances the frame parser by one received byte and returns the result
  // beat that the byte must produce.
  function automatic scrb_result_t parse_rx_byte(input logic [7:0] rx);
    scrb_result_t res;
    logic         in_range;
    res = '0;
    case (parse_phase)
      WR_INDEX: begin
        held_index  = rx;
        parse_phase = WR_DATA;
      end
      WR_DATA: begin
        in_range = int'(held_index) < int'(BANK_SIZE);
        if (in_range) begin
          bank_copy[held_index] = rx;
        end
        parse_phase     = AWAIT_CMD;
        res.write_done  = in_range;
        res.index_error = !in_range;
        res.frame_end   = 1'b1;
      end
      RD_INDEX: begin
        held_index      = rx;
        in_range        = int'(rx) < int'(BANK_SIZE);
        parse_phase     = RD_DUMMY;
        res.reply_valid = 1'b1;
        res.reply_byte  = in_range ? bank_copy[rx] : 8'h00;
        res.index_error = !in_range;
      end
      RD_DUMMY: begin
        parse_phase   = AWAIT_CMD;
        res.frame_end = 1'b1;
      end
      default: begin
        // A write command wins when both command bytes are equal.
        if (rx == write_cmd) begin
          parse_phase = WR_INDEX;
        end else if (rx == read_cmd) begin
          parse_phase = RD_INDEX;
        end else begin
          parse_phase   = AWAIT_CMD;
          res.frame_end = 1'b1;
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    scrb_result_t got;
    scrb_result_t want;
    if (!rst_ni) begin
      parse_phase = AWAIT_CMD;
      write_cmd   = WRITE_CMD_RESET;
      read_cmd    = READ_CMD_RESET;
      held_index  = '0;
      foreach (bank_copy[i]) begin
        bank_copy[i] = '0;
      end
      owed_results.delete();
      owed_count_o = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_WRITE_CMD) begin
          write_cmd = cfg_data_i;
        end else begin
          read_cmd = cfg_data_i;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{reply_valid_i, reply_byte_i, write_done_i, index_error_i, frame_end_i};
        if (owed_results.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result beat rv=%0b rb=%02h wd=%0b ie=%0b fe=%0b",
                   $time, got.reply_valid, got.reply_byte, got.write_done,
                   got.index_error, got.frame_end);
        end else begin
          want = owed_results.pop_front();
          if (got !== want) begin
            fail_count_o++;
            $display("%0t: result beat mismatch: expected rv=%0b rb=%02h wd=%0b ie=%0b fe=%0b",
                     $time, want.reply_valid, want.reply_byte, want.write_done,
                     want.index_error, want.frame_end);
            $display("%0t:                       actual rv=%0b rb=%02h wd=%0b ie=%0b fe=%0b",
                     $time, got.reply_valid, got.reply_byte, got.write_done,
                     got.index_error, got.frame_end);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        owed_results.push_back(parse_rx_byte(rx_byte_i));
      end
      owed_count_o = owed_results.size();
    end
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

// Drives byte beats into the register bank and gives the verdict. All
// prediction and comparison happens in the frame checker beside the block.
module tb_top;
  import scrb_pkg::*;

  localparam int unsigned BANK = BANK_SIZE_DEFAULT;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          PHASE_BYTES = 245;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       reply_valid_o;
  logic [7:0] reply_byte_o;
  logic       write_done_o;
  logic       index_error_o;
  logic       frame_end_o;

  int         owed_count;
  int         fail_count;
  int         quiet_cycles;
  int         bytes_sent;
  logic       idle_on;
  logic [7:0] cur_write_cmd;
  logic [7:0] cur_read_cmd;

  serial_command_register_bank #(
    .BANK_SIZE(BANK)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .reply_valid_o(reply_valid_o),
    .reply_byte_o (reply_byte_o),
    .write_done_o (write_done_o),
    .index_error_o(index_error_o),
    .frame_end_o  (frame_end_o)
  );

  scrb_frame_checker #(
    .BANK_SIZE(BANK)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .reply_valid_i(reply_valid_o),
    .reply_byte_i (reply_byte_o),
    .write_done_i (write_done_o),
    .index_error_i(index_error_o),
    .frame_end_i  (frame_end_o),
    .owed_count_o (owed_count),
    .fail_count_o (fail_count)
  );

  always #1 clk_i = ~clk_i;

  // The receiver stalls at random while idling is enabled.
  always @(negedge clk_i) begin
    out_stall_i = idle_on && ($urandom_range(99) < 29);
  end

  // Watchdog: ends the run when no beat and no register write has been
  // accepted for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offers one byte beat and returns at the falling edge after it was taken.
  // Valid stays high afterwards so that back-to-back beats need no toggle.
  task automatic send_byte(input logic [7:0] rx);
    while (idle_on && ($urandom_range(99) < 29)) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i  = rx;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] first, input logic [7:0] index,
                            input logic [7:0] last);
    send_byte(first);
    send_byte(index);
    send_byte(last);
  endtask

  // Mostly well-formed frames with random content; the rest are stray bytes
  // that may also open a frame and so shift the framing of what follows.
  task automatic send_random_traffic(input int count);
    int         pick;
    logic [7:0] index;
    count = bytes_sent + count;
    while (bytes_sent < count) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        send_byte(8'($urandom_range(255)));
      end else begin
        if ($urandom_range(99) < 80) begin
          index = 8'($urandom_range(BANK - 1));
        end else begin
          index = 8'($urandom_range(255));
        end
        send_frame((pick < 62) ? cur_write_cmd : cur_read_cmd, index,
                   8'($urandom_range(255)));
      end
    end
  endtask

  // Lets the block drain completely, then loads new command bytes.
  task automatic load_commands(input logic [7:0] wr_cmd, input logic [7:0] rd_cmd);
    in_valid_i = 1'b0;
    while (owed_count != 0) begin
      @(negedge clk_i);
    end
    cfg_we_i    = 1'b1;
    cfg_index_i = CFG_WRITE_CMD;
    cfg_data_i  = wr_cmd;
    @(negedge clk_i);
    cfg_index_i = CFG_READ_CMD;
    cfg_data_i  = rd_cmd;
    @(negedge clk_i);
    cfg_we_i      = 1'b0;
    cur_write_cmd = wr_cmd;
    cur_read_cmd  = rd_cmd;
  endtask

  initial begin
    logic [7:0] wr_list [6];
    logic [7:0] rd_list [6];
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_WRITE_CMD;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    rx_byte_i     = '0;
    out_stall_i   = 1'b0;
    quiet_cycles  = 0;
    bytes_sent    = 0;
    idle_on       = 1'b1;
    cur_write_cmd = WRITE_CMD_RESET;
    cur_read_cmd  = READ_CMD_RESET;
    wr_list = '{8'h80, 8'h00, 8'hff, 8'h00, 8'h00, WRITE_CMD_RESET};
    rd_list = '{8'h80, 8'hff, 8'h00, 8'h00, 8'h00, READ_CMD_RESET};
    wr_list[3] = 8'($urandom_range(255));
    rd_list[3] = 8'($urandom_range(255));
    wr_list[4] = 8'($urandom_range(255));
    rd_list[4] = 8'($urandom_range(255));

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed frames under the reset command bytes.
    send_frame(cur_read_cmd, 8'h00, 8'h00);              // bank reads zero after reset
    send_frame(cur_write_cmd, 8'(BANK - 1), 8'hff);      // last entry, all ones
    send_frame(cur_read_cmd, 8'(BANK - 1), cur_read_cmd); // command byte as dummy
    send_frame(cur_write_cmd, 8'(BANK), 8'h55);          // first index past the bank
    send_frame(cur_write_cmd, 8'hff, cur_write_cmd);     // largest index, dropped
    send_frame(cur_read_cmd, 8'hff, 8'h00);              // out-of-range read replies zero
    send_frame(cur_write_cmd, 8'h00, cur_read_cmd);      // command byte as data
    send_byte(8'h00);                                    // lone bytes end at once
    send_byte(8'hff);
    send_frame(cur_read_cmd, 8'h00, 8'hff);

    send_random_traffic(PHASE_BYTES);

    // Equal commands first, then the extremes, random pairs and the reset pair.
    // The third setting runs with no idling on either side.
    for (int p = 0; p < 6; p++) begin
      load_commands(wr_list[p], rd_list[p]);
      idle_on = (p != 2);
      send_random_traffic(PHASE_BYTES);
    end

    in_valid_i = 1'b0;
    while (owed_count != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
